// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file rlfp_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/rlfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rlfp_pkg
// types and constants of the recursive lock fast path
// ----------------------------------------------------------------------------
package rlfp_pkg;

  localparam int unsigned WordWidth    = 32;
  localparam int unsigned MemSizeWidth = 33;

  // bytes covered by one lock record
  localparam logic [MemSizeWidth:0] RecordBytes = 34'd28;

  localparam logic [MemSizeWidth-1:0] MemSizeReset = 33'd536870912;

  localparam logic [WordWidth-1:0] FreeCount = 32'hFFFF_FFFF;
  localparam logic [WordWidth-1:0] MaxCount  = 32'h7FFF_FFFF;
  localparam logic [WordWidth-1:0] AllOnes   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_ENTER = 2'd0,
    MODE_TRY   = 2'd1,
    MODE_LEAVE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    DISP_SLOW   = 2'd0,
    DISP_DONE   = 2'd1,
    DISP_SIGNAL = 2'd2
  } disp_e;

  typedef struct packed {
    logic [1:0]           mode;
    logic [WordWidth-1:0] section_address;
    logic [7:0]           section_type;
    logic [WordWidth-1:0] lock_count;
    logic [WordWidth-1:0] recursion_count;
    logic [WordWidth-1:0] owner_thread;
    logic [WordWidth-1:0] current_thread;
  } request_t;

  typedef struct packed {
    disp_e                disposition;
    logic                 acquired;
    logic                 write_back;
    logic [WordWidth-1:0] new_lock_count;
    logic [WordWidth-1:0] new_recursion_count;
    logic [WordWidth-1:0] new_owner;
  } result_t;

endpackage

// ===== design/rlfp_stage.sv =====
// ----------------------------------------------------------------------------
// rlfp_stage
// one pipeline register with valid/ready flow control
// ----------------------------------------------------------------------------
module rlfp_stage #(
  parameter int unsigned Width = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q, valid_d;
  logic [Width-1:0] data_q, data_d;

  // stage frees up when empty or when its item leaves this cycle
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ready_o) begin
      valid_d = valid_i;
      if (valid_i) begin
        data_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/rlfp_decide.sv =====
// ----------------------------------------------------------------------------
// rlfp_decide
// request check and acquire / re-enter / release decision
// ----------------------------------------------------------------------------
module rlfp_decide (
  input  rlfp_pkg::request_t                     req_i,
  input  logic [rlfp_pkg::MemSizeWidth-1:0]      mem_size_i,
  output rlfp_pkg::result_t                      res_o
);

  logic [rlfp_pkg::MemSizeWidth:0] rec_end;
  logic                            rec_valid;
  logic                            own_match;
  logic                            lc_neg;
  logic                            lc_ge;
  logic                            is_free;
  logic                            can_reenter;
  logic                            leave_ok;
  logic [rlfp_pkg::WordWidth-1:0]  lc_dec;
  logic [rlfp_pkg::WordWidth-1:0]  rc_dec;

  // record end must not pass the memory size
  assign rec_end = {2'b00, req_i.section_address} + rlfp_pkg::RecordBytes;

  assign rec_valid = (req_i.current_thread != '0) && (req_i.section_address != '0)
                  && (req_i.section_type == 8'd1) && (req_i.section_address[1:0] == 2'b00)
                  && (rec_end <= {1'b0, mem_size_i});

  assign own_match = req_i.owner_thread == req_i.current_thread;
  assign lc_neg    = req_i.lock_count[rlfp_pkg::WordWidth-1];
  assign rc_dec    = req_i.recursion_count - 32'd1;
  assign lc_dec    = req_i.lock_count - 32'd1;
  assign lc_ge     = req_i.lock_count >= rc_dec;

  assign is_free = (req_i.lock_count == rlfp_pkg::FreeCount)
                && (req_i.recursion_count == '0) && (req_i.owner_thread == '0);

  assign can_reenter = own_match && (req_i.recursion_count != '0)
                    && (req_i.recursion_count != rlfp_pkg::AllOnes) && !lc_neg
                    && (req_i.lock_count != rlfp_pkg::MaxCount) && lc_ge;

  assign leave_ok = own_match && (req_i.recursion_count != '0) && !lc_neg && lc_ge;

  always_comb begin
    res_o.disposition         = rlfp_pkg::DISP_SLOW;
    res_o.acquired            = 1'b0;
    res_o.write_back          = 1'b0;
    res_o.new_lock_count      = req_i.lock_count;
    res_o.new_recursion_count = req_i.recursion_count;
    res_o.new_owner           = req_i.owner_thread;
    if (rec_valid) begin
      case (req_i.mode)
        rlfp_pkg::MODE_LEAVE: begin
          if (leave_ok) begin
            res_o.write_back     = 1'b1;
            res_o.new_lock_count = lc_dec;
            if (req_i.recursion_count > 32'd1) begin
              res_o.new_recursion_count = rc_dec;
              res_o.disposition         = rlfp_pkg::DISP_DONE;
            end else begin
              // final release, wake a waiter unless the lock went free
              res_o.new_recursion_count = '0;
              res_o.new_owner           = '0;
              res_o.disposition         = (lc_dec == rlfp_pkg::FreeCount)
                                        ? rlfp_pkg::DISP_DONE : rlfp_pkg::DISP_SIGNAL;
            end
          end
        end
        rlfp_pkg::MODE_ENTER, rlfp_pkg::MODE_TRY: begin
          if (is_free) begin
            res_o.disposition         = rlfp_pkg::DISP_DONE;
            res_o.acquired            = 1'b1;
            res_o.write_back          = 1'b1;
            res_o.new_lock_count      = '0;
            res_o.new_recursion_count = 32'd1;
            res_o.new_owner           = req_i.current_thread;
          end else if (can_reenter) begin
            res_o.disposition         = rlfp_pkg::DISP_DONE;
            res_o.acquired            = 1'b1;
            res_o.write_back          = 1'b1;
            res_o.new_lock_count      = req_i.lock_count + 32'd1;
            res_o.new_recursion_count = req_i.recursion_count + 32'd1;
          end else if (req_i.mode == rlfp_pkg::MODE_TRY) begin
            res_o.disposition = rlfp_pkg::DISP_DONE;
          end
        end
        default: begin
          res_o.disposition = rlfp_pkg::DISP_SLOW;
        end
      endcase
    end
  end

endmodule

// ===== design/recursive_lock_fast_path.sv =====
// ----------------------------------------------------------------------------
// recursive_lock_fast_path
// fast-path decision unit for a recursive lock record
// ----------------------------------------------------------------------------
// Each item carries one enter, try-enter or leave request with the lock
// record's words already decoded. The unit checks the record (nonzero,
// word aligned, fully inside memory_size, type byte 1, caller nonzero) and
// then decides among first acquire, recursive re-entry, nested release and
// final release. It returns a disposition (slow path, done, done and wake a
// waiter), an acquired flag and the words to store with a write-back flag.
// When no write-back is due the three words come back unchanged.
//
// Throughput is one item per clock while the output is not stalled. An item
// passes through an input register, the decision logic, then a result
// register. Both registers hold their item while the output is stalled and
// take a new one in the same cycle the old one leaves, so tready stays high
// as long as the result side keeps up.
//
// memory_size is written through the cfg channel, which is always ready;
// write it only while no item is in flight.
// ----------------------------------------------------------------------------
module recursive_lock_fast_path (
  input  logic          clk_i,
  input  logic          rst_ni,

  // configuration: memory_size
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [32:0]   cfg_data_i,

  // request items
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [31:0] section_address, [39:32] section_type, [71:40] lock_count,
  // [103:72] recursion_count, [135:104] owner_thread, [167:136] current_thread
  input  logic [167:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]    s_axis_tuser,

  // result items
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [1:0] disposition, [2] acquired, [3] write_back, [35:4] new_lock_count,
  // [67:36] new_recursion_count, [99:68] new_owner, [103:100] zero
  output logic [103:0]  m_axis_tdata
);

  localparam int unsigned ReqWidth = $bits(rlfp_pkg::request_t);
  localparam int unsigned ResWidth = $bits(rlfp_pkg::result_t);

  logic [rlfp_pkg::MemSizeWidth-1:0] mem_size_q;

  rlfp_pkg::request_t req_in;
  rlfp_pkg::request_t req_stage;
  rlfp_pkg::result_t  res_comb;
  rlfp_pkg::result_t  res_out;

  logic [ReqWidth-1:0] req_stage_bits;
  logic [ResWidth-1:0] res_out_bits;
  logic                stage_valid;
  logic                stage_ready;

  // config register, always accepts
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= rlfp_pkg::MemSizeReset;
    end else if (cfg_valid_i) begin
      mem_size_q <= cfg_data_i;
    end
  end

  // unpack request item, first field in the low bits
  always_comb begin
    req_in.mode            = s_axis_tuser;
    req_in.section_address = s_axis_tdata[31:0];
    req_in.section_type    = s_axis_tdata[39:32];
    req_in.lock_count      = s_axis_tdata[71:40];
    req_in.recursion_count = s_axis_tdata[103:72];
    req_in.owner_thread    = s_axis_tdata[135:104];
    req_in.current_thread  = s_axis_tdata[167:136];
  end

  // input register
  rlfp_stage #(
    .Width (ReqWidth)
  ) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (req_in),
    .valid_o (stage_valid),
    .ready_i (stage_ready),
    .data_o  (req_stage_bits)
  );

  assign req_stage = rlfp_pkg::request_t'(req_stage_bits);

  // decision logic between the two registers
  rlfp_decide u_decide (
    .req_i      (req_stage),
    .mem_size_i (mem_size_q),
    .res_o      (res_comb)
  );

  // result register
  rlfp_stage #(
    .Width (ResWidth)
  ) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid),
    .ready_o (stage_ready),
    .data_i  (res_comb),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res_out_bits)
  );

  assign res_out = rlfp_pkg::result_t'(res_out_bits);

  // pack result item
  assign m_axis_tdata = {4'b0000, res_out.new_owner, res_out.new_recursion_count,
                         res_out.new_lock_count, res_out.write_back, res_out.acquired,
                         res_out.disposition};

endmodule

// ===== design/rlfp_checker.sv =====
// ----------------------------------------------------------------------------
// rlfp_checker
// port-level checks on the recursive lock fast path
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlfp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  // stalled result holds its value
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

  // a write back always comes with a completed disposition
  `ASSERT_IMPLIES(a_wb_done, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[1:0] == rlfp_pkg::DISP_DONE || m_axis_tdata[1:0] == rlfp_pkg::DISP_SIGNAL, "write back without completion")

  // acquiring is a plain completion with a store
  `ASSERT_IMPLIES(a_acq_store, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[3] && m_axis_tdata[1:0] == rlfp_pkg::DISP_DONE, "acquire without store")

  // waking a waiter only on a final release, which clears the owner
  `ASSERT_IMPLIES(a_signal_release, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[1:0] == rlfp_pkg::DISP_SIGNAL, m_axis_tdata[3] && !m_axis_tdata[2] && m_axis_tdata[99:68] == 32'd0 && m_axis_tdata[67:36] == 32'd0, "bad signal result")

  // padding bits stay zero
  `ASSERT_IMPLIES(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[103:100] == 4'b0000, "padding not zero")

endmodule

bind recursive_lock_fast_path rlfp_checker u_rlfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
